### design/mmbd_pkg.sv
// Package for the memory-map bus decoder: request and region codes, address map,
// memory sizes and the decoded-access struct. No dependencies.
`timescale 1ns / 1ps

package mmbd_pkg;

  // Cartridge ROM size in bytes; must be a power of two from 1 KiB to 32 MiB
  localparam int ROM_BYTES = 4194304;
  localparam int ROM_AW    = $clog2(ROM_BYTES);

  // Region sizes in bytes
  localparam int BOARD_BYTES = 32'h0004_0000;
  localparam int CHIP_BYTES  = 32'h0000_8000;
  localparam int IO_BYTES    = 32'h0000_0400;
  localparam int PAL_BYTES   = 32'h0000_0400;
  localparam int VID_BYTES   = 32'h0001_8000;
  localparam int OBJ_BYTES   = 32'h0000_0400;
  localparam int SAVE_BYTES  = 32'h0001_0000;

  // Address map, inclusive bounds
  localparam logic [31:0] BOARD_LO = 32'h0200_0000;
  localparam logic [31:0] BOARD_HI = 32'h0203_FFFF;
  localparam logic [31:0] CHIP_LO  = 32'h0300_0000;
  localparam logic [31:0] CHIP_HI  = 32'h0300_7FFF;
  localparam logic [31:0] IO_LO    = 32'h0400_0000;
  localparam logic [31:0] IO_HI    = 32'h0400_03FE;
  localparam logic [31:0] PAL_LO   = 32'h0500_0000;
  localparam logic [31:0] PAL_HI   = 32'h0500_03FF;
  localparam logic [31:0] VID_LO   = 32'h0600_0000;
  localparam logic [31:0] VID_HI   = 32'h0601_7FFF;
  localparam logic [31:0] OBJ_LO   = 32'h0700_0000;
  localparam logic [31:0] OBJ_HI   = 32'h0700_03FF;
  localparam logic [31:0] ROM_LO   = 32'h0800_0000;
  localparam logic [31:0] ROM_HI   = 32'h0DFF_FFFF;
  localparam logic [31:0] SAVE_LO  = 32'h0E00_0000;
  localparam logic [31:0] SAVE_HI  = 32'h0E00_FFFF;
  localparam logic [31:0] DISP_ADDR = 32'h0400_0004;

  // Offset within a region, and region size (one bit wider to hold 32 MiB)
  localparam int OFF_W  = 25;
  localparam int SIZE_W = OFF_W + 1;

  // Each region is four byte lanes; a row holds one byte of each lane
  localparam int MAX_ROWS = (ROM_BYTES / 4 > BOARD_BYTES / 4) ? ROM_BYTES / 4 : BOARD_BYTES / 4;
  localparam int ROW_W    = $clog2(MAX_ROWS);

  // The display-status byte sits in lane 0, row 1 of the IO region
  localparam logic [ROW_W-1:0] DISP_ROW = ROW_W'(1);

  localparam int NUM_REGIONS = 8;

  typedef enum logic [2:0] {
    REQ_LDB, REQ_LDH, REQ_LDSB, REQ_LDSH, REQ_LDW, REQ_STRB, REQ_STRH, REQ_STRW
  } req_e;

  typedef enum logic [2:0] {
    RGN_BOARD, RGN_CHIP, RGN_IO, RGN_PAL, RGN_VID, RGN_OBJ, RGN_ROM, RGN_SAVE
  } region_e;

  // Decoded access for one bus word
  typedef struct packed {
    logic                  mapped;
    logic                  disp;
    logic                  store;
    region_e               region;
    logic [1:0]            off_lo;
    logic [3:0]            lane_en;
    logic [3:0][1:0]       lane_k;    // byte of the bus word carried by each lane
    logic [3:0][ROW_W-1:0] lane_row;
  } dec_t;

  // Rows per lane of each region
  function automatic int region_rows(region_e r);
    int rows;
    case (r)
      RGN_BOARD: rows = BOARD_BYTES / 4;
      RGN_CHIP:  rows = CHIP_BYTES / 4;
      RGN_IO:    rows = IO_BYTES / 4;
      RGN_PAL:   rows = PAL_BYTES / 4;
      RGN_VID:   rows = VID_BYTES / 4;
      RGN_OBJ:   rows = OBJ_BYTES / 4;
      RGN_ROM:   rows = ROM_BYTES / 4;
      RGN_SAVE:  rows = SAVE_BYTES / 4;
      default:   rows = BOARD_BYTES / 4;
    endcase
    return rows;
  endfunction

  // Bytes of the bus word touched by a request, lowest byte first
  function automatic logic [3:0] req_mask(req_e t);
    logic [3:0] m;
    case (t)
      REQ_LDB, REQ_LDSB, REQ_STRB: m = 4'b0001;
      REQ_LDH, REQ_LDSH, REQ_STRH: m = 4'b0011;
      default:                     m = 4'b1111;
    endcase
    return m;
  endfunction

endpackage

### design/mmbd_byte_ram.sv
// Generic byte-wide single-port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module mmbd_byte_ram #(
  parameter int  ROWS = 256,
  localparam int AW   = $clog2(ROWS)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic          re_i,
  input  logic [AW-1:0] addr_i,
  input  logic [7:0]    wdata_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem_q [ROWS];
  logic [7:0] rdata_q;

  // One address a cycle: a write, a read into the output register, or both
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/mmbd_addr_dec.sv
// Address decoder: maps a bus address and request type onto a region and
// per-lane rows with wrap at the region end. Depends on mmbd_pkg.
`timescale 1ns / 1ps

module mmbd_addr_dec
  import mmbd_pkg::*;
(
  input  req_e        req_type_i,
  input  logic [31:0] addr_i,
  output dec_t        dec_o
);

  logic                    mapped;
  region_e                 region;
  logic [OFF_W-1:0]        off;
  logic [SIZE_W-1:0]       size;
  logic [3:0]              mask;
  logic [3:0][1:0]         kb;
  logic [3:0][SIZE_W-1:0]  idx;

  // Region match and offset from the region base
  always_comb begin
    mapped = 1'b1;
    region = RGN_BOARD;
    off    = '0;
    if (addr_i >= BOARD_LO && addr_i <= BOARD_HI) begin
      region = RGN_BOARD;
      off    = OFF_W'(addr_i - BOARD_LO);
    end else if (addr_i >= CHIP_LO && addr_i <= CHIP_HI) begin
      region = RGN_CHIP;
      off    = OFF_W'(addr_i - CHIP_LO);
    end else if (addr_i >= IO_LO && addr_i <= IO_HI) begin
      region = RGN_IO;
      off    = OFF_W'(addr_i - IO_LO);
    end else if (addr_i >= PAL_LO && addr_i <= PAL_HI) begin
      region = RGN_PAL;
      off    = OFF_W'(addr_i - PAL_LO);
    end else if (addr_i >= VID_LO && addr_i <= VID_HI) begin
      region = RGN_VID;
      off    = OFF_W'(addr_i - VID_LO);
    end else if (addr_i >= OBJ_LO && addr_i <= OBJ_HI) begin
      region = RGN_OBJ;
      off    = OFF_W'(addr_i - OBJ_LO);
    end else if (addr_i >= ROM_LO && addr_i <= ROM_HI) begin
      // windows are 32 MiB aligned, so the low bits are the ROM offset
      region = RGN_ROM;
      off    = OFF_W'(addr_i[ROM_AW-1:0]);
    end else if (addr_i >= SAVE_LO && addr_i <= SAVE_HI) begin
      region = RGN_SAVE;
      off    = OFF_W'(addr_i - SAVE_LO);
    end else begin
      mapped = 1'b0;
    end
  end

  // Per lane: which byte it carries, and its row after wrapping at the end
  always_comb begin
    size = SIZE_W'(4 * region_rows(region));
    mask = req_mask(req_type_i);
    for (int b = 0; b < 4; b++) begin
      kb[b]  = 2'(b) - off[1:0];
      idx[b] = {1'b0, off} + SIZE_W'(kb[b]);
      if (idx[b] >= size) begin
        idx[b] = idx[b] - size;
      end
    end
  end

  always_comb begin
    dec_o.mapped = mapped;
    dec_o.disp   = (addr_i == DISP_ADDR);
    dec_o.store  = (req_type_i >= REQ_STRB);
    dec_o.region = region;
    dec_o.off_lo = off[1:0];
    for (int b = 0; b < 4; b++) begin
      dec_o.lane_en[b]  = mapped && mask[kb[b]];
      dec_o.lane_k[b]   = kb[b];
      dec_o.lane_row[b] = idx[b][ROW_W+1:2];
    end
  end

endmodule

### design/memory_map_bus_decoder.sv
// Top level of the memory-map bus decoder: input register, address decode,
// banked region RAMs and result register. Depends on mmbd_pkg, mmbd_addr_dec, mmbd_byte_ram.
`timescale 1ns / 1ps

// One bus access (byte, halfword or word load, sign-extending load or store) is
// taken per cycle while s_axis_tready is high; its read_data is registered.
// Unmapped accesses and stores off the display-status byte return zero. Every
// region is held as four byte-lane RAMs, so an access of up to four bytes,
// aligned or not and wrapping at the region end, is one read or write per lane.
// After reset a clearing pass zeroes all regions, one row per cycle, through
// MAX_ROWS rows (1,048,576 at a 4 MiB ROM; the larger of ROM_BYTES/4 and 65,536);
// s_axis_tready stays low until it ends. ROM_BYTES must be a power of two. The
// display-status byte at 0x04000004 is a flip-flop: any access to exactly that
// address flips bit 0 and returns the new byte.
module memory_map_bus_decoder
  import mmbd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,   // req_type[2:0], addr[34:3], write_data[66:35], zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // read_data[31:0]
);

  // Handshake and pipeline control
  logic out_rdy, en2, en1, in_acc;

  // Clearing pass
  logic             clr_busy_q;
  logic [ROW_W-1:0] clr_q;

  // Input register
  logic        s1_vq;
  req_e        s1_type_q;
  logic [31:0] s1_addr_q;
  logic [31:0] s1_wdata_q;
  dec_t        dec;

  // Display-status byte
  logic [7:0] disp_q;

  // Stage after the RAM access
  logic       s2_vq;
  req_e       s2_type_q;
  logic       s2_mapped_q, s2_disp_q, s2_store_q, s2_b4_q;
  region_e    s2_region_q;
  logic [1:0] s2_off_lo_q;
  logic [7:0] s2_snap_q;

  // Result register
  logic        out_vq;
  logic [31:0] out_data_q;
  logic [31:0] out_data_d;

  logic [NUM_REGIONS-1:0][3:0][7:0] rd_data;
  logic [3:0][7:0]                  lane_wd;
  logic [3:0]                       wr_lane;
  logic [3:0][7:0]                  rd_lanes;
  logic [3:0][7:0]                  bytes;
  logic [3:0]                       s2_mask;

  assign out_rdy       = !out_vq || m_axis_tready;
  assign en2           = !s2_vq || out_rdy;
  assign en1           = !s1_vq || en2;
  assign s_axis_tready = en1 && !clr_busy_q;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  mmbd_addr_dec u_dec (
    .req_type_i (s1_type_q),
    .addr_i     (s1_addr_q),
    .dec_o      (dec)
  );

  // Store data and write strobes per lane
  always_comb begin
    for (int b = 0; b < 4; b++) begin
      lane_wd[b] = s1_wdata_q[8*dec.lane_k[b] +: 8];
      wr_lane[b] = s1_vq && en2 && dec.mapped && dec.store && !dec.disp && dec.lane_en[b];
    end
  end

  // Region RAMs, four byte lanes each
  for (genvar r = 0; r < NUM_REGIONS; r++) begin : g_region
    localparam int ROWS = region_rows(region_e'(r));
    localparam int AW   = $clog2(ROWS);
    for (genvar b = 0; b < 4; b++) begin : g_lane
      logic          we;
      logic [AW-1:0] addr;
      logic [7:0]    wdata;

      always_comb begin
        if (clr_busy_q) begin
          we    = (32'(clr_q) < 32'(ROWS));
          addr  = clr_q[AW-1:0];
          wdata = '0;
        end else begin
          we    = wr_lane[b] && (dec.region == region_e'(r));
          addr  = dec.lane_row[b][AW-1:0];
          wdata = lane_wd[b];
        end
      end

      mmbd_byte_ram #(.ROWS(ROWS)) u_ram (
        .clk_i   (clk_i),
        .we_i    (we),
        .re_i    (en2),
        .addr_i  (addr),
        .wdata_i (wdata),
        .rdata_o (rd_data[r][b])
      );
    end
  end

  // Control state: clearing pass, valid bits, display-status byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_q      <= '0;
      s1_vq      <= 1'b0;
      s2_vq      <= 1'b0;
      out_vq     <= 1'b0;
      disp_q     <= '0;
    end else begin
      if (clr_busy_q) begin
        clr_q <= clr_q + ROW_W'(1);
        if (clr_q == ROW_W'(MAX_ROWS - 1)) begin
          clr_busy_q <= 1'b0;
        end
      end
      if (en1) begin
        s1_vq <= in_acc;
      end
      if (en2) begin
        s2_vq <= s1_vq;
      end
      if (out_rdy) begin
        out_vq <= s2_vq;
      end
      if (s1_vq && en2 && dec.mapped) begin
        if (dec.disp) begin
          disp_q <= disp_q ^ 8'h01;
        end else if (dec.store && dec.region == RGN_IO && dec.lane_en[0] &&
                     dec.lane_row[0] == DISP_ROW) begin
          disp_q <= lane_wd[0];
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_type_q  <= req_e'(s_axis_tdata[2:0]);
      s1_addr_q  <= s_axis_tdata[34:3];
      s1_wdata_q <= s_axis_tdata[66:35];
    end
    if (en2) begin
      s2_type_q   <= s1_type_q;
      s2_mapped_q <= dec.mapped;
      s2_disp_q   <= dec.disp;
      s2_store_q  <= dec.store;
      s2_region_q <= dec.region;
      s2_off_lo_q <= dec.off_lo;
      s2_b4_q     <= (dec.region == RGN_IO) && dec.lane_en[0] && (dec.lane_row[0] == DISP_ROW);
      s2_snap_q   <= disp_q;
    end
    if (out_rdy) begin
      out_data_q <= out_data_d;
    end
  end

  // Lane rotate, byte mask, sign extension, and the zero or display-status result
  always_comb begin
    rd_lanes = rd_data[s2_region_q];
    if (s2_b4_q) begin
      rd_lanes[0] = s2_snap_q;
    end
    s2_mask = req_mask(s2_type_q);
    for (int k = 0; k < 4; k++) begin
      bytes[k] = s2_mask[k] ? rd_lanes[2'(k) + s2_off_lo_q] : 8'h00;
    end
    out_data_d = bytes;
    if (s2_type_q == REQ_LDSB && bytes[0][7]) begin
      out_data_d[31:8] = '1;
    end else if (s2_type_q == REQ_LDSH && bytes[1][7]) begin
      out_data_d[31:16] = '1;
    end
    if (!s2_mapped_q) begin
      out_data_d = '0;
    end else if (s2_disp_q) begin
      out_data_d = {24'h0, s2_snap_q ^ 8'h01};
    end else if (s2_store_q) begin
      out_data_d = '0;
    end
  end

  assign m_axis_tvalid = out_vq;
  assign m_axis_tdata  = out_data_q;

  // No word is taken while the clearing pass runs
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> !s_axis_tready)
    else $error("word accepted during clearing pass");

  // A display-status access flips the stored byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_vq && en2 && dec.mapped && dec.disp) |=> (disp_q == ($past(disp_q) ^ 8'h01)))
    else $error("display-status byte not toggled");

  // A store other than to the display-status byte leaves a zero result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_rdy && s2_vq && s2_mapped_q && s2_store_q && !s2_disp_q) |=> (out_data_q == '0))
    else $error("store returned non-zero data");

endmodule

### sim/memory_map_bus_checker.sv
// Checker for the memory-map bus decoder: watches both stream channels, predicts
// each read_data word from a sparse copy of the memory map and compares in order.
// Depends on mmbd_pkg for the request codes and the address map.
`timescale 1ns / 1ps

module memory_map_bus_checker
  import mmbd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  input  logic        req_ready_i,
  input  logic [71:0] req_word_i,    // req_type[2:0], addr[34:3], write_data[66:35], zero
  input  logic        rsp_valid_i,
  input  logic        rsp_ready_i,
  input  logic [31:0] rsp_word_i,    // read_data[31:0]
  output int          mismatches_o,
  output int          outstanding_o
);

  typedef struct {
    logic [31:0] data;
    logic [31:0] addr;
    req_e        kind;
  } due_t;

  // Bytes written so far, keyed by region base plus offset; absent bytes read 0
  logic [7:0] mem_bytes [logic [31:0]];
  due_t       read_data_q [$];
  int         errs = 0;

  function automatic logic [7:0] peek_byte(logic [31:0] key);
    return mem_bytes.exists(key) ? mem_bytes[key] : 8'h00;
  endfunction

  // Decode one access, update the copy of the map and return its read_data
  function automatic logic [31:0] bus_access(req_e kind, logic [31:0] a, logic [31:0] wd);
    logic [31:0] lo;
    logic [31:0] span;
    logic [31:0] off;
    logic [31:0] key;
    logic [31:0] rd;
    int          nbytes;
    bit          is_store;
    rd  = '0;
    lo  = '0;
    off = '0;
    span = 32'd1;
    if (a >= BOARD_LO && a <= BOARD_HI) begin
      lo = BOARD_LO; span = BOARD_BYTES; off = a - lo;
    end else if (a >= CHIP_LO && a <= CHIP_HI) begin
      lo = CHIP_LO; span = CHIP_BYTES; off = a - lo;
    end else if (a >= IO_LO && a <= IO_HI) begin
      // display status: flip bit 0 whatever the request, return the byte
      if (a == DISP_ADDR) begin
        mem_bytes[DISP_ADDR] = peek_byte(DISP_ADDR) ^ 8'h01;
        return {24'h0, mem_bytes[DISP_ADDR]};
      end
      lo = IO_LO; span = IO_BYTES; off = a - lo;
    end else if (a >= PAL_LO && a <= PAL_HI) begin
      lo = PAL_LO; span = PAL_BYTES; off = a - lo;
    end else if (a >= VID_LO && a <= VID_HI) begin
      lo = VID_LO; span = VID_BYTES; off = a - lo;
    end else if (a >= OBJ_LO && a <= OBJ_HI) begin
      lo = OBJ_LO; span = OBJ_BYTES; off = a - lo;
    end else if (a >= ROM_LO && a <= ROM_HI) begin
      // three wait windows, each mirroring the ROM every ROM_BYTES
      lo = ROM_LO; span = ROM_BYTES;
      off = ((a - ROM_LO) & 32'h01FF_FFFF) % 32'(ROM_BYTES);
    end else if (a >= SAVE_LO && a <= SAVE_HI) begin
      lo = SAVE_LO; span = SAVE_BYTES; off = a - lo;
    end else begin
      return '0;
    end

    case (kind)
      REQ_LDB, REQ_LDSB, REQ_STRB: nbytes = 1;
      REQ_LDH, REQ_LDSH, REQ_STRH: nbytes = 2;
      default:                     nbytes = 4;
    endcase
    is_store = (kind == REQ_STRB || kind == REQ_STRH || kind == REQ_STRW);

    // little-endian, wrapping at the region end
    for (int k = 0; k < nbytes; k++) begin
      key = lo + ((off + 32'(k)) % span);
      if (is_store)
        mem_bytes[key] = wd[8*k +: 8];
      else
        rd[8*k +: 8] = peek_byte(key);
    end

    if (is_store)
      rd = '0;
    else if (kind == REQ_LDSB && rd[7])
      rd[31:8] = '1;
    else if (kind == REQ_LDSH && rd[15])
      rd[31:16] = '1;
    return rd;
  endfunction

  // Result words are checked against the oldest prediction, then new words predicted
  always @(posedge clk_i) begin : track
    due_t due;
    if (rst_ni) begin
      if (rsp_valid_i && rsp_ready_i) begin
        if (read_data_q.size() == 0) begin
          errs++;
          $display("%0t: unexpected read_data word: expected none, actual %h",
                   $time, rsp_word_i);
        end else begin
          due = read_data_q.pop_front();
          if (rsp_word_i !== due.data) begin
            errs++;
            $display("%0t: read_data mismatch (%s @ %h): expected %h, actual %h",
                     $time, due.kind.name(), due.addr, due.data, rsp_word_i);
          end
        end
      end
      if (req_valid_i && req_ready_i) begin
        due.kind = req_e'(req_word_i[2:0]);
        due.addr = req_word_i[34:3];
        due.data = bus_access(due.kind, due.addr, req_word_i[66:35]);
        read_data_q.push_back(due);
      end
    end
    mismatches_o  <= errs;
    outstanding_o <= read_data_q.size();
  end

endmodule

### sim/memory_map_bus_decoder_test.sv
// Testbench top for the memory-map bus decoder: clock, reset, request stimulus
// and result back-pressure. Depends on mmbd_pkg, memory_map_bus_decoder and
// memory_map_bus_checker.
`timescale 1ns / 1ps

module memory_map_bus_decoder_test;
  import mmbd_pkg::*;

  localparam int RANDOM_WORDS = 1350;
  // clearing pass after reset, then every word waiting out the longest gaps
  localparam int CYCLE_LIMIT  = 4 * MAX_ROWS + 1_000_000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata = '0;   // req_type[2:0], addr[34:3], write_data[66:35], zero
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // read_data[31:0]

  int fails;
  int outstanding;
  int cycles = 0;
  bit steady = 1'b0;

  memory_map_bus_decoder uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  memory_map_bus_checker checker_inst (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_valid_i   (s_axis_tvalid),
    .req_ready_i   (s_axis_tready),
    .req_word_i    (s_axis_tdata),
    .rsp_valid_i   (m_axis_tvalid),
    .rsp_ready_i   (m_axis_tready),
    .rsp_word_i    (m_axis_tdata),
    .mismatches_o  (fails),
    .outstanding_o (outstanding)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Timeout
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Idle length: mostly none or short, now and then long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Result side: ready stretches broken by stalls, some long stall-free runs
  initial begin : sink_stall
    int hold;
    @(posedge clk_i);
    forever begin
      hold = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 400) : $urandom_range(1, 12);
      m_axis_tready <= 1'b1;
      repeat (hold) @(posedge clk_i);
      hold = idle_len();
      if (hold > 0) begin
        m_axis_tready <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
    end
  end

  // Offer one access word and hold it until taken
  task automatic send_access(req_e kind, logic [31:0] a, logic [31:0] wd);
    int gap;
    gap = steady ? 0 : idle_len();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'b0, wd, a, kind};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Hold off until every predicted word has come back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
  endtask

  function automatic logic [31:0] pick_offset(int span);
    case ($urandom_range(0, 3))
      0:       return $urandom_range(0, 15);
      1:       return span - 1 - $urandom_range(0, 7);
      2:       return $urandom_range(0, 255);
      default: return $urandom_range(0, span - 1);
    endcase
  endfunction

  // Mostly mapped addresses near region edges and in hot windows
  function automatic logic [31:0] rand_addr();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel == 0) return $urandom();
    if (sel == 1) begin
      case ($urandom_range(0, 9))
        0:       return BOARD_LO - 1;
        1:       return BOARD_HI + 1;
        2:       return CHIP_HI + 1;
        3:       return IO_HI + 1;
        4:       return PAL_HI + 1;
        5:       return VID_HI + 1;
        6:       return OBJ_HI + 1;
        7:       return ROM_LO - 1;
        8:       return ROM_HI + 1;
        default: return SAVE_HI + 1;
      endcase
    end
    if (sel == 2) return DISP_ADDR;
    case ($urandom_range(0, 7))
      0:       return BOARD_LO + pick_offset(BOARD_BYTES);
      1:       return CHIP_LO + pick_offset(CHIP_BYTES);
      2:       return IO_LO + pick_offset(IO_BYTES - 1);
      3:       return PAL_LO + pick_offset(PAL_BYTES);
      4:       return VID_LO + pick_offset(VID_BYTES);
      5:       return OBJ_LO + pick_offset(OBJ_BYTES);
      // one of three windows, at one of the ROM mirrors
      6:       return ROM_LO + 32'h0200_0000 * $urandom_range(0, 2)
                      + pick_offset(ROM_BYTES) + 32'(ROM_BYTES) * $urandom_range(0, 7);
      default: return SAVE_LO + pick_offset(SAVE_BYTES);
    endcase
  endfunction

  function automatic logic [31:0] rand_data();
    case ($urandom_range(0, 11))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h0000_0080;
      3:       return 32'h0000_8000;
      default: return $urandom();
    endcase
  endfunction

  initial begin : stimulus
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // BIOS and unmapped space
    send_access(REQ_LDW,  32'h0000_0000, 32'h0);
    send_access(REQ_STRW, 32'h0000_0100, 32'hFFFF_FFFF);
    send_access(REQ_LDW,  32'hFFFF_FFFF, 32'h0);
    // word store wrapping at the board RAM end, read back both ways
    send_access(REQ_STRW, BOARD_HI - 1,  32'hDEAD_BEEF);
    send_access(REQ_LDW,  BOARD_LO,      32'h0);
    send_access(REQ_LDSH, BOARD_HI - 1,  32'h0);
    send_access(REQ_LDSB, BOARD_HI,      32'h0);
    // sign and zero extension
    send_access(REQ_STRB, CHIP_LO,       32'hFFFF_FF80);
    send_access(REQ_LDSB, CHIP_LO,       32'h0);
    send_access(REQ_LDB,  CHIP_LO,       32'h0);
    send_access(REQ_STRH, CHIP_HI,       32'h1234_8001);
    send_access(REQ_LDH,  CHIP_HI,       32'h0);
    // display status flips on any request; a span from below is ordinary
    send_access(REQ_LDB,  DISP_ADDR,     32'h0);
    send_access(REQ_STRW, DISP_ADDR,     32'hFFFF_FFFF);
    send_access(REQ_LDSH, DISP_ADDR,     32'h0);
    send_access(REQ_LDW,  DISP_ADDR - 1, 32'h0);
    // top IO byte is unmapped, but reachable by wrapping from the last one
    send_access(REQ_STRW, IO_HI,         32'hA5A5_5A5A);
    send_access(REQ_STRB, IO_HI + 1,     32'h0000_00FF);
    send_access(REQ_LDW,  IO_HI,         32'h0);
    send_access(REQ_LDB,  IO_HI + 1,     32'h0);
    // ROM mirrors, windows and its size wrap
    send_access(REQ_STRW, 32'h0C3F_FFFE, 32'hCAFE_F00D);
    send_access(REQ_LDW,  32'h0DFF_FFFE, 32'h0);
    send_access(REQ_LDW,  32'h0A40_0000, 32'h0);
    // save RAM wrap: halfword store, then a signed halfword load
    send_access(REQ_STRH, SAVE_HI,       32'h0000_ABCD);
    send_access(REQ_LDSH, SAVE_HI,       32'h0);
    drain();

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i % 100 == 0)
        steady = ($urandom_range(0, 3) == 0);
      if (i % 300 == 299)
        drain();
      send_access(req_e'($urandom_range(0, 7)), rand_addr(), rand_data());
    end

    drain();
    repeat (10) @(posedge clk_i);
    if (fails == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

### files.f
design/mmbd_pkg.sv
design/mmbd_byte_ram.sv
design/mmbd_addr_dec.sv
design/memory_map_bus_decoder.sv
sim/memory_map_bus_checker.sv
sim/memory_map_bus_decoder_test.sv
